// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PTPI_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PTPI_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PTPI_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PTPI_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/ptpi_pkg.sv =====
// Types, constants and tables of the planar pose integrator.
`timescale 1ns / 1ps
package ptpi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 30;
    localparam logic [29:0] HEAD_K = 30'd716770142;
    localparam logic [31:0] CORDIC_X0 = 32'd652032875;
    localparam logic [13:0] USEC_ODD = 14'd15625;
    localparam logic [31:0] TIMEOUT_RST = 32'd500000;
    localparam logic [14:0] LIN_LIM_RST = 15'd4096;
    localparam logic [14:0] ANG_LIM_RST = 15'd8192;
    localparam int MUL_BITS = 32;
    localparam int DIV_BITS = 48;

    typedef enum logic [2:0] {
        REG_TIMEOUT  = 3'd0,
        REG_LIN_LIM  = 3'd1,
        REG_ANG_LIM  = 3'd2,
        REG_START_X  = 3'd3,
        REG_START_Y  = 3'd4,
        REG_START_H  = 3'd5,
        REG_HEIGHT   = 3'd6,
        REG_UNUSED   = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WZDT,
        ST_HEAD,
        ST_ROT,
        ST_P_CVX,
        ST_P_SVY,
        ST_P_SVX,
        ST_P_CVY,
        ST_AH,
        ST_AL,
        ST_DIV,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/planar_twist_pose_integrator_unit.sv =====
// Top level of the planar twist pose integrator: sequencer, state and stream ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A command word (tuser 0) latches velocities. A tick word (tuser 1)
// with positive dt runs through one shared bit-serial multiplier, an iterative CORDIC
// and a serial divider: wz*dt and the heading step, the rotation, four products for
// the world-frame velocity, then per axis two multiplier passes and one division,
// before the pose word is loaded. A tick with dt of zero or less gives no word.
// The input is taken only between items; a finished pose waits in the output register.
module planar_twist_pose_integrator_unit #(
    parameter int CORDIC_STEPS = ptpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // now_us[31:0], vx_cmd[47:32], vy_cmd[63:48], wz_cmd[79:64]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pos_x, pos_y, pos_z, heading, 32 bits each
    output logic         m_tuser,   // cmd_expired
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    ptpi_pkg::state_t state_reg, state_next;

    logic [31:0] timeout_reg, height_reg;
    logic [14:0] lin_lim_reg, ang_lim_reg;
    logic [31:0] pose_x_reg, pose_y_reg, yaw_reg, last_tick_reg, last_cmd_reg;
    logic [15:0] held_vx_reg, held_vy_reg, held_wz_reg;
    logic [15:0] vx_reg, vy_reg, wz_reg;
    logic [31:0] dt_reg;
    logic        expired_reg;
    logic [63:0] tmp_reg, wx_reg, wy_reg, ah_reg;
    logic        axis_reg;
    logic        launched_reg;
    logic        m_tvalid_reg;
    logic [127:0] m_data_reg;
    logic        m_user_reg;

    logic        s_acc;
    logic [31:0] now;
    logic [31:0] dt_w, age_w;
    logic        exp_w;
    logic        start;
    logic        mul_start, cor_start, div_start;
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_done, cor_done, div_done;
    logic [63:0] mul_p;
    logic [31:0] cos_q, sin_q;
    logic [47:0] div_q;
    logic [63:0] v_sel, v_abs;
    logic [47:0] q_sum;
    logic [48:0] r_rnd;
    logic [31:0] disp;
    logic [63:0] head_sum;
    logic        emit_go;

    function automatic logic [15:0] clamp(input logic [15:0] v, input logic [14:0] lim);
        logic signed [16:0] sv;
        logic signed [16:0] sl;
        logic signed [16:0] r;
        sv = $signed({v[15], v});
        sl = $signed({2'b00, lim});
        if (sv > sl) begin
            r = sl;
        end else if (sv < -sl) begin
            r = -sl;
        end else begin
            r = sv;
        end
        return r[15:0];
    endfunction

    assign s_tready  = (state_reg == ptpi_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign now       = s_tdata[31:0];
    assign dt_w      = now - last_tick_reg;
    assign age_w     = now - last_cmd_reg;
    assign exp_w     = !age_w[31] && ({1'b0, age_w[30:0]} > timeout_reg);
    assign emit_go   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptpi_pkg::ST_IDLE: begin
                if (s_acc && s_tuser && !dt_w[31] && (dt_w != 32'd0)) begin
                    state_next = ptpi_pkg::ST_WZDT;
                end
            end
            ptpi_pkg::ST_WZDT:  if (mul_done) state_next = ptpi_pkg::ST_HEAD;
            ptpi_pkg::ST_HEAD:  if (mul_done) state_next = ptpi_pkg::ST_ROT;
            ptpi_pkg::ST_ROT:   if (cor_done) state_next = ptpi_pkg::ST_P_CVX;
            ptpi_pkg::ST_P_CVX: if (mul_done) state_next = ptpi_pkg::ST_P_SVY;
            ptpi_pkg::ST_P_SVY: if (mul_done) state_next = ptpi_pkg::ST_P_SVX;
            ptpi_pkg::ST_P_SVX: if (mul_done) state_next = ptpi_pkg::ST_P_CVY;
            ptpi_pkg::ST_P_CVY: if (mul_done) state_next = ptpi_pkg::ST_AH;
            ptpi_pkg::ST_AH:    if (mul_done) state_next = ptpi_pkg::ST_AL;
            ptpi_pkg::ST_AL:    if (mul_done) state_next = ptpi_pkg::ST_DIV;
            ptpi_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = axis_reg ? ptpi_pkg::ST_EMIT : ptpi_pkg::ST_AH;
                end
            end
            ptpi_pkg::ST_EMIT:  if (emit_go) state_next = ptpi_pkg::ST_IDLE;
            default:            state_next = ptpi_pkg::ST_IDLE;
        endcase
    end

    // unit launches and operand selection
    always_comb begin
        start     = !launched_reg;
        mul_start = 1'b0;
        cor_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = dt_reg;
        unique case (state_reg)
            ptpi_pkg::ST_WZDT: begin
                mul_start = start;
                mul_a     = {{48{wz_reg[15]}}, wz_reg};
            end
            ptpi_pkg::ST_HEAD: begin
                mul_start = start;
                mul_a     = tmp_reg;
                mul_b     = {2'b00, ptpi_pkg::HEAD_K};
            end
            ptpi_pkg::ST_ROT:   cor_start = start;
            ptpi_pkg::ST_P_CVX: begin
                mul_start = start;
                mul_a     = {{32{cos_q[31]}}, cos_q};
                mul_b     = {{16{vx_reg[15]}}, vx_reg};
            end
            ptpi_pkg::ST_P_SVY: begin
                mul_start = start;
                mul_a     = {{32{sin_q[31]}}, sin_q};
                mul_b     = {{16{vy_reg[15]}}, vy_reg};
            end
            ptpi_pkg::ST_P_SVX: begin
                mul_start = start;
                mul_a     = {{32{sin_q[31]}}, sin_q};
                mul_b     = {{16{vx_reg[15]}}, vx_reg};
            end
            ptpi_pkg::ST_P_CVY: begin
                mul_start = start;
                mul_a     = {{32{cos_q[31]}}, cos_q};
                mul_b     = {{16{vy_reg[15]}}, vy_reg};
            end
            ptpi_pkg::ST_AH: begin
                mul_start = start;
                mul_a     = {31'd0, v_abs[63:31]};
            end
            ptpi_pkg::ST_AL: begin
                mul_start = start;
                mul_a     = {33'd0, v_abs[30:0]};
            end
            ptpi_pkg::ST_DIV:   div_start = start;
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign v_sel    = axis_reg ? wy_reg : wx_reg;
    assign v_abs    = v_sel[63] ? (64'd0 - v_sel) : v_sel;
    assign q_sum    = ah_reg[47:0] + {15'd0, mul_p[63:31]};
    assign r_rnd    = ({1'b0, div_q} + 49'd1) >> 1;
    assign disp     = v_sel[63] ? (32'd0 - r_rnd[31:0]) : r_rnd[31:0];
    assign head_sum = mul_p + 64'h0000_0000_8000_0000;

    ptpi_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .prod   (mul_p)
    );

    ptpi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cor_start),
        .angle  (yaw_reg),
        .done   (cor_done),
        .cos_q  (cos_q),
        .sin_q  (sin_q)
    );

    ptpi_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (q_sum),
        .done   (div_done),
        .quo    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ptpi_pkg::ST_IDLE;
            launched_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            timeout_reg   <= ptpi_pkg::TIMEOUT_RST;
            lin_lim_reg   <= ptpi_pkg::LIN_LIM_RST;
            ang_lim_reg   <= ptpi_pkg::ANG_LIM_RST;
            height_reg    <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            yaw_reg       <= '0;
            last_tick_reg <= '0;
            last_cmd_reg  <= '0;
            held_vx_reg   <= '0;
            held_vy_reg   <= '0;
            held_wz_reg   <= '0;
            axis_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= (state_next == state_reg) ? (launched_reg || start) : 1'b0;
            if (cfg_valid) begin
                unique case (ptpi_pkg::reg_idx_t'(cfg_index))
                    ptpi_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                    ptpi_pkg::REG_LIN_LIM: lin_lim_reg <= cfg_data[14:0];
                    ptpi_pkg::REG_ANG_LIM: ang_lim_reg <= cfg_data[14:0];
                    ptpi_pkg::REG_START_X: pose_x_reg  <= cfg_data;
                    ptpi_pkg::REG_START_Y: pose_y_reg  <= cfg_data;
                    ptpi_pkg::REG_START_H: yaw_reg     <= cfg_data;
                    ptpi_pkg::REG_HEIGHT:  height_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_acc) begin
                if (!s_tuser) begin
                    held_vx_reg  <= s_tdata[47:32];
                    held_vy_reg  <= s_tdata[63:48];
                    held_wz_reg  <= s_tdata[79:64];
                    last_cmd_reg <= now;
                end else begin
                    last_tick_reg <= now;
                    dt_reg        <= dt_w;
                    expired_reg   <= exp_w;
                    axis_reg      <= 1'b0;
                    vx_reg <= exp_w ? 16'd0 : clamp(held_vx_reg, lin_lim_reg);
                    vy_reg <= exp_w ? 16'd0 : clamp(held_vy_reg, lin_lim_reg);
                    wz_reg <= exp_w ? 16'd0 : clamp(held_wz_reg, ang_lim_reg);
                end
            end
            if (mul_done) begin
                unique case (state_reg)
                    ptpi_pkg::ST_WZDT:  tmp_reg <= mul_p;
                    ptpi_pkg::ST_HEAD:  yaw_reg <= yaw_reg + head_sum[63:32];
                    ptpi_pkg::ST_P_CVX: tmp_reg <= mul_p;
                    ptpi_pkg::ST_P_SVY: wx_reg  <= tmp_reg - mul_p;
                    ptpi_pkg::ST_P_SVX: tmp_reg <= mul_p;
                    ptpi_pkg::ST_P_CVY: wy_reg  <= tmp_reg + mul_p;
                    ptpi_pkg::ST_AH:    ah_reg  <= mul_p;
                    default: begin
                    end
                endcase
            end
            if (div_done) begin
                if (axis_reg) begin
                    pose_y_reg <= pose_y_reg + disp;
                end else begin
                    pose_x_reg <= pose_x_reg + disp;
                end
                axis_reg <= 1'b1;
            end
            if ((state_reg == ptpi_pkg::ST_EMIT) && emit_go) begin
                m_tvalid_reg <= 1'b1;
                m_data_reg   <= {yaw_reg, height_reg, pose_y_reg, pose_x_reg};
                m_user_reg   <= expired_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `PTPI_ASSERT_NEXT(a_emit_loads, aclk, aresetn, (state_reg == ptpi_pkg::ST_EMIT) && emit_go, m_tvalid)
    `PTPI_ASSERT_IMPL(a_cordic_in_rot, aclk, aresetn, cor_done, state_reg == ptpi_pkg::ST_ROT)
    `PTPI_ASSERT_IMPL(a_div_in_div, aclk, aresetn, div_done, state_reg == ptpi_pkg::ST_DIV)
endmodule

// ===== rtl/core/ptpi_mul.sv =====
// Bit-serial multiplier: 64-bit multiplicand times signed 32-bit multiplier, low 64 bits.
`timescale 1ns / 1ps
module ptpi_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [63:0] prod
);
    localparam int CW = $clog2(ptpi_pkg::MUL_BITS);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   a_reg;
    logic [31:0]   b_reg;
    logic          last;
    logic [63:0]   addend;

    assign last   = (cnt_reg == CW'(ptpi_pkg::MUL_BITS - 1));
    // top bit of the multiplier weighs negative
    assign addend = last ? (64'd0 - a_reg) : a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
            end else if (busy_reg) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + addend;
                end
                a_reg   <= {a_reg[62:0], 1'b0};
                b_reg   <= {1'b0, b_reg[31:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ===== rtl/core/ptpi_div.sv =====
// Restoring divider by the microsecond constant, one quotient bit per cycle.
`timescale 1ns / 1ps
module ptpi_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] num,
    output logic        done,
    output logic [47:0] quo
);
    localparam int CW = $clog2(ptpi_pkg::DIV_BITS);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [47:0]   n_reg;
    logic [47:0]   q_reg;
    logic [13:0]   rem_reg;
    logic [14:0]   trial;
    logic          fits;
    logic [14:0]   diff;

    assign trial = {rem_reg, n_reg[47]};
    assign fits  = (trial >= {1'b0, ptpi_pkg::USEC_ODD});
    assign diff  = trial - {1'b0, ptpi_pkg::USEC_ODD};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= num;
                q_reg    <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[13:0] : trial[13:0];
                q_reg   <= {q_reg[46:0], fits};
                n_reg   <= {n_reg[46:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ptpi_pkg::DIV_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ===== rtl/core/ptpi_cordic.sv =====
// Iterative rotation-mode CORDIC giving cos and sin in Q1.30 of a binary angle.
`timescale 1ns / 1ps
module ptpi_cordic #(
    parameter int CORDIC_STEPS = ptpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] angle,
    output logic        done,
    output logic [31:0] cos_q,
    output logic [31:0] sin_q
);
    localparam int IW = $clog2(CORDIC_STEPS + 1);

    logic               busy_reg;
    logic               done_reg;
    logic               flip_reg;
    logic [IW-1:0]      iter_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic [31:0]        fold_chk;
    logic [31:0]        folded;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [33:0] xo;
    logic signed [33:0] yo;

    assign fold_chk = angle + 32'h4000_0000;
    assign folded   = fold_chk[31] ? angle + 32'h8000_0000 : angle;
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = $signed({2'b00, ptpi_pkg::atan_entry(5'(iter_reg))});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                flip_reg <= fold_chk[31];
                x_reg    <= $signed({2'b00, ptpi_pkg::CORDIC_X0});
                y_reg    <= '0;
                z_reg    <= $signed({{2{folded[31]}}, folded});
            end else if (busy_reg) begin
                if (!z_reg[33]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign xo    = flip_reg ? -x_reg : x_reg;
    assign yo    = flip_reg ? -y_reg : y_reg;
    assign done  = done_reg;
    assign cos_q = xo[31:0];
    assign sin_q = yo[31:0];
endmodule
